// ===== design/tick_clock_and_led_timers_defines.svh =====
// Assertion macros used by the top-level design file.
`ifndef TICK_CLOCK_AND_LED_TIMERS_DEFINES_SVH
`define TICK_CLOCK_AND_LED_TIMERS_DEFINES_SVH

`ifndef SYNTHESIS
`define TCL_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("check failed: lbl");
`define TCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed: lbl");
`define TCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed: lbl");
`else
`define TCL_ASSERT(lbl, cond)
`define TCL_ASSERT_IMP(lbl, ante, cons)
`define TCL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/tcl_pkg.sv =====
package tcl_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned MillisW = 10;
  localparam int unsigned SecsW   = 6;
  localparam int unsigned MinsW   = 6;
  localparam int unsigned HoursW  = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0]   StepMs        = 16'd10;
  localparam logic [TimeW-1:0]   PeriodReset   = 16'd1000;
  localparam logic [TimeW-1:0]   OnTimeReset   = 16'd500;
  localparam logic [MillisW:0]   MsPerSec      = 11'd1000;
  localparam logic [MillisW:0]   MsStep        = 11'd10;
  localparam logic [SecsW-1:0]   SecsPerMin    = 6'd60;
  localparam logic [MinsW-1:0]   MinsPerHour   = 6'd60;
  localparam logic [HoursW-1:0]  HoursPerDay   = 5'd24;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlinkPeriod = 2'd0,
    CfgBlinkOnTime = 2'd1
  } tcl_cfg_idx_e;

  typedef struct packed {
    logic             tick;
    logic             service_request;
    logic [TimeW-1:0] link_led_load;
    logic [TimeW-1:0] store_led_load;
  } tcl_in_t;

  typedef struct packed {
    logic               blink_led;
    logic               link_led;
    logic               store_led;
    logic               watchdog_kick;
    logic [TimeW-1:0]   elapsed_ms;
    logic [MillisW-1:0] millis;
    logic [SecsW-1:0]   secs;
    logic [MinsW-1:0]   mins;
    logic [HoursW-1:0]  hours;
  } tcl_out_t;

  typedef struct packed {
    logic en;
    logic tick;
  } tcl_step_t;

endpackage

// ===== design/tcl_blink.sv =====
module tcl_blink import tcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcl_step_t        step_i,
  input  logic [TimeW-1:0] period_i,
  input  logic [TimeW-1:0] on_time_i,
  output logic             led_o
);

  logic [TimeW-1:0] phase_q, phase_d;
  logic             led_q, led_d;
  logic [TimeW:0]   sum;

  always_comb begin
    sum     = {1'b0, phase_q} + {1'b0, StepMs};
    phase_d = phase_q;
    led_d   = led_q;
    if (step_i.tick) begin
      phase_d = (sum >= {1'b0, period_i}) ? '0 : sum[TimeW-1:0];
      led_d   = (phase_d < on_time_i);
    end
  end

  assign led_o = led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      led_q   <= 1'b0;
    end else if (step_i.en) begin
      phase_q <= phase_d;
      led_q   <= led_d;
    end
  end

endmodule

// ===== design/tcl_countdown.sv =====
module tcl_countdown import tcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcl_step_t        step_i,
  input  logic [TimeW-1:0] load_i,
  output logic             led_o
);

  logic [TimeW-1:0] remaining_q, remaining_d;
  logic [TimeW-1:0] loaded;
  logic             led_q, led_d;

  always_comb begin
    loaded      = (load_i != '0) ? load_i : remaining_q;
    remaining_d = loaded;
    led_d       = led_q;
    if (step_i.tick) begin
      led_d       = (loaded != '0);
      remaining_d = (loaded >= StepMs) ? (loaded - StepMs) : '0;
    end
  end

  assign led_o = led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      led_q       <= 1'b0;
    end else if (step_i.en) begin
      remaining_q <= remaining_d;
      led_q       <= led_d;
    end
  end

endmodule

// ===== design/tcl_clock.sv =====
module tcl_clock import tcl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcl_step_t          step_i,
  output logic [TimeW-1:0]   elapsed_o,
  output logic [MillisW-1:0] millis_o,
  output logic [SecsW-1:0]   secs_o,
  output logic [MinsW-1:0]   mins_o,
  output logic [HoursW-1:0]  hours_o
);

  logic [TimeW-1:0]   elapsed_q, elapsed_d;
  logic [MillisW-1:0] ms_q, ms_d;
  logic [SecsW-1:0]   sec_q, sec_d;
  logic [MinsW-1:0]   min_q, min_d;
  logic [HoursW-1:0]  hour_q, hour_d;
  logic [MillisW:0]   ms_sum;
  logic [SecsW-1:0]   sec_inc;
  logic [MinsW-1:0]   min_inc;
  logic [HoursW-1:0]  hour_inc;

  always_comb begin
    ms_sum    = {1'b0, ms_q} + MsStep;
    sec_inc   = sec_q + 6'd1;
    min_inc   = min_q + 6'd1;
    hour_inc  = hour_q + 5'd1;
    elapsed_d = elapsed_q;
    ms_d      = ms_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    if (step_i.tick) begin
      elapsed_d = elapsed_q + StepMs;
      ms_d      = ms_sum[MillisW-1:0];
      if (ms_sum >= MsPerSec) begin
        ms_d  = '0;
        sec_d = sec_inc;
        if (sec_inc >= SecsPerMin) begin
          sec_d = '0;
          min_d = min_inc;
          if (min_inc >= MinsPerHour) begin
            min_d  = '0;
            hour_d = (hour_inc >= HoursPerDay) ? '0 : hour_inc;
          end
        end
      end
    end
  end

  assign elapsed_o = elapsed_d;
  assign millis_o  = ms_d;
  assign secs_o    = sec_d;
  assign mins_o    = min_d;
  assign hours_o   = hour_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      ms_q      <= '0;
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
    end else if (step_i.en) begin
      elapsed_q <= elapsed_d;
      ms_q      <= ms_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
    end
  end

endmodule

// ===== design/tick_clock_and_led_timers.sv =====
// A request is held in the input register; its result enters the result register once the
// output is free. Throughput: one request per cycle while results are taken; the input and
// result registers let the block take a new request while a finished result still waits to be taken.
// Reset clears all timers, LEDs, the clock and the pending kick, sets the blink period
// to 1000 and the on-time to 500, and leaves both channels empty.
`include "tick_clock_and_led_timers_defines.svh"

module tick_clock_and_led_timers import tcl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcl_in_t            in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcl_out_t           out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  tcl_in_t          in_q;
  logic             out_valid_q, out_valid_d;
  tcl_out_t         out_q, out_d;
  logic [TimeW-1:0] period_q, period_d;
  logic [TimeW-1:0] on_time_q, on_time_d;
  logic             kick_q, kick_d;
  logic             kick_pend;
  logic             adv;
  logic             in_acc;
  tcl_step_t        step;

  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign step.en   = adv;
  assign step.tick = in_q.tick;

  always_comb begin
    period_d  = period_q;
    on_time_d = on_time_q;
    if (cfg_valid_i) begin
      case (tcl_cfg_idx_e'(cfg_index_i))
        CfgBlinkPeriod: period_d  = cfg_data_i;
        CfgBlinkOnTime: on_time_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign kick_pend              = kick_q || in_q.service_request;
  assign kick_d                 = in_q.tick ? 1'b0 : kick_pend;
  assign out_d.watchdog_kick    = in_q.tick && kick_pend;

  tcl_blink u_blink (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .period_i  (period_q),
    .on_time_i (on_time_q),
    .led_o     (out_d.blink_led)
  );

  tcl_countdown u_link (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .load_i (in_q.link_led_load),
    .led_o  (out_d.link_led)
  );

  tcl_countdown u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .load_i (in_q.store_led_load),
    .led_o  (out_d.store_led)
  );

  tcl_clock u_clock (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .elapsed_o (out_d.elapsed_ms),
    .millis_o  (out_d.millis),
    .secs_o    (out_d.secs),
    .mins_o    (out_d.mins),
    .hours_o   (out_d.hours)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      kick_q      <= 1'b0;
      period_q    <= PeriodReset;
      on_time_q   <= OnTimeReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      period_q    <= period_d;
      on_time_q   <= on_time_d;
      if (adv) begin
        kick_q <= kick_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  `TCL_ASSERT_NEXT(a_no_kick_without_tick, adv && !in_q.tick, !out_q.watchdog_kick)
  `TCL_ASSERT_NEXT(a_kick_cleared_on_tick, adv && in_q.tick, !kick_q)
  `TCL_ASSERT_IMP(a_clock_in_range, out_valid_q,
                  out_q.millis <= 10'd990 && out_q.secs < SecsPerMin &&
                  out_q.mins < MinsPerHour && out_q.hours < HoursPerDay)

endmodule
